[sv/frst_pkg.sv]
// Shared types and codes of the frequency ranked symbol table.
package frst_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_SORT  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CA_SYM = 2'd0,
    CA_RSD = 2'd1,
    CA_A   = 2'd2,
    CA_B   = 2'd3
  } cnt_addr_e;

  typedef enum logic [1:0] {
    RA_RM1 = 2'd0,
    RA_I   = 2'd1,
    RA_IM1 = 2'd2
  } rs_addr_e;

  typedef enum logic [1:0] {
    WS_OTH = 2'd0,
    WS_SYM = 2'd1,
    WS_A   = 2'd2,
    WS_B   = 2'd3
  } rs_wr_e;

  localparam int unsigned InWidth  = 16;
  localparam int unsigned OutWidth = 112;

  typedef struct packed {
    logic      cap_in;
    cnt_addr_e cnt_sel;
    rs_addr_e  rs_sel;
    logic      rs_we;
    rs_wr_e    rs_ws;
    logic      ld_query;
    logic      ld_add;
    logic      ld_oth;
    logic      ld_a;
    logic      ld_b;
    logic      ld_ca;
    logic      prom_step;
    logic      i_inc;
    logic      srt_swap;
    logic      ld_out;
  } ctl_t;

  typedef struct packed {
    cmd_e cmd;
    logic sym_ok;
    logic vld_rd;
    logic r_zero;
    logic i_zero;
    logic i_end;
    logic prom_win;
    logic sort_win;
  } sts_t;

endpackage

[sv/frst_datapath.sv]
// Datapath: symbol tables, counters, comparators and result register.
module frst_datapath #(
  parameter int unsigned SYMBOLS     = 256,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [frst_pkg::InWidth-1:0]    in_data_i,
  input  frst_pkg::ctl_t                  ctl_i,
  output frst_pkg::sts_t                  sts_o,
  output logic [frst_pkg::OutWidth-1:0]   out_data_o
);

  localparam int unsigned SW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int unsigned DW = SW + 1;
  localparam int unsigned CW = COUNT_WIDTH;

  logic [SW-1:0] rs_mem [SYMBOLS];
  logic [SW-1:0] sr_mem [SYMBOLS];
  logic [CW-1:0] cnt_mem [SYMBOLS];
  logic [SYMBOLS-1:0] vld_q;

  frst_pkg::cmd_e cmd_q;
  logic [7:0]    sym_q;
  logic [SW-1:0] rs_rd_q, sr_rd_q, oth_q, a_q, b_q, r_q, steps_q;
  logic [CW-1:0] cnt_rd_q, cs_q, ca_q;
  logic          vld_rd_q, pres_q, new_q;
  logic [DW-1:0] i_q, distinct_q;
  logic [14:0]   swaps_q;
  logic [31:0]   total_q;
  logic [frst_pkg::OutWidth-1:0] out_q;

  logic [SW-1:0] sym_idx, cnt_addr, rs_addr, wa, wv, i_idx, im1_idx;
  logic [DW-1:0] i_m1;
  logic [CW-1:0] cnt_inc, cnt_wd;
  logic [31:0]   count32;

  assign sym_idx = sym_q[SW-1:0];
  assign i_m1    = i_q - 1'b1;
  assign i_idx   = i_q[SW-1:0];
  assign im1_idx = i_m1[SW-1:0];
  assign cnt_inc = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + 1'b1;
  assign cnt_wd  = vld_rd_q ? cnt_inc : CW'(1);

  always_comb begin
    case (ctl_i.cnt_sel)
      frst_pkg::CA_SYM: cnt_addr = sym_idx;
      frst_pkg::CA_RSD: cnt_addr = rs_rd_q;
      frst_pkg::CA_A:   cnt_addr = a_q;
      default:          cnt_addr = b_q;
    endcase
    case (ctl_i.rs_sel)
      frst_pkg::RA_RM1: rs_addr = r_q - 1'b1;
      frst_pkg::RA_I:   rs_addr = i_idx;
      default:          rs_addr = im1_idx;
    endcase
    case (ctl_i.rs_ws)
      frst_pkg::WS_OTH: begin wa = r_q;     wv = oth_q;   end
      frst_pkg::WS_SYM: begin wa = r_q;     wv = sym_idx; end
      frst_pkg::WS_A:   begin wa = im1_idx; wv = a_q;     end
      default:          begin wa = i_idx;   wv = b_q;     end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rs_rd_q  <= rs_mem[rs_addr];
    sr_rd_q  <= sr_mem[sym_idx];
    cnt_rd_q <= cnt_mem[cnt_addr];
    vld_rd_q <= vld_q[cnt_addr];
    if (ctl_i.rs_we) begin
      rs_mem[wa] <= wv;
      sr_mem[wv] <= wa;
    end
    if (ctl_i.ld_add) begin
      cnt_mem[sym_idx] <= cnt_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      distinct_q <= '0;
      total_q    <= '0;
    end else if (ctl_i.ld_add) begin
      if (total_q != '1) total_q <= total_q + 1'b1;
      if (!vld_rd_q) begin
        vld_q[sym_idx] <= 1'b1;
        distinct_q     <= distinct_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap_in) begin
      cmd_q   <= frst_pkg::cmd_e'(in_data_i[1:0]);
      sym_q   <= in_data_i[9:2];
      pres_q  <= 1'b0;
      new_q   <= 1'b0;
      r_q     <= '0;
      cs_q    <= '0;
      steps_q <= '0;
      swaps_q <= '0;
      i_q     <= '0;
    end
    if (ctl_i.ld_query && vld_rd_q) begin
      pres_q <= 1'b1;
      r_q    <= sr_rd_q;
      cs_q   <= cnt_rd_q;
    end
    if (ctl_i.ld_add) begin
      pres_q <= 1'b1;
      cs_q   <= cnt_wd;
      new_q  <= !vld_rd_q;
      r_q    <= vld_rd_q ? sr_rd_q : distinct_q[SW-1:0];
    end
    if (ctl_i.ld_oth) oth_q <= rs_rd_q;
    if (ctl_i.ld_a) a_q <= rs_rd_q;
    if (ctl_i.ld_b) b_q <= rs_rd_q;
    if (ctl_i.ld_ca) ca_q <= cnt_rd_q;
    if (ctl_i.prom_step) begin
      r_q     <= r_q - 1'b1;
      steps_q <= steps_q + 1'b1;
    end
    if (ctl_i.i_inc) i_q <= i_q + 1'b1;
    if (ctl_i.srt_swap) begin
      i_q     <= i_m1;
      swaps_q <= swaps_q + 1'b1;
    end
    if (ctl_i.ld_out) out_q <= {6'd0, total_q, 9'(distinct_q), swaps_q, 8'(steps_q),
                                count32, 8'(r_q), new_q, pres_q};
  end

  assign count32 = (cs_q > CW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(cs_q);

  always_comb begin
    sts_o.cmd      = cmd_q;
    sts_o.sym_ok   = ({1'b0, sym_q} < 9'(SYMBOLS));
    sts_o.vld_rd   = vld_rd_q;
    sts_o.r_zero   = (r_q == '0);
    sts_o.i_zero   = (i_q == '0);
    sts_o.i_end    = (i_q >= distinct_q);
    sts_o.prom_win = (cs_q > cnt_rd_q) || (cs_q == cnt_rd_q && sym_idx < oth_q);
    sts_o.sort_win = (ca_q > cnt_rd_q) || (ca_q == cnt_rd_q && a_q < b_q);
  end

  assign out_data_o = out_q;

endmodule

[sv/frst_ctrl.sv]
// Controller: sequences add, promote, sort and query over the datapath.
module frst_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  logic           cfg_valid_i,
  input  logic           cfg_data_i,
  input  frst_pkg::sts_t sts_i,
  output frst_pkg::ctl_t ctl_o
);

  typedef enum logic [3:0] {
    IDLE, DISP, ADD_UPD, Q_RES, PR_RD, PR_CNT, PR_CMP, PR_FIN,
    SR_CHK, SR_RB, SR_CA, SR_CB, SR_CMP, SR_SW, DONE
  } state_e;

  state_e state_q, state_d;
  logic   mv_q, mv_d, auto_q;

  assign in_ready_o  = (state_q == IDLE);
  assign out_valid_o = mv_q;

  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    mv_d    = mv_q && !out_ready_i;
    unique case (state_q)
      IDLE: begin
        if (in_valid_i) begin
          ctl_o.cap_in = 1'b1;
          state_d = DISP;
        end
      end
      DISP: begin
        ctl_o.cnt_sel = frst_pkg::CA_SYM;
        unique case (sts_i.cmd)
          frst_pkg::CMD_ADD:   state_d = sts_i.sym_ok ? ADD_UPD : DONE;
          frst_pkg::CMD_QUERY: state_d = sts_i.sym_ok ? Q_RES : DONE;
          frst_pkg::CMD_SORT:  state_d = auto_q ? DONE : SR_CHK;
          default:             state_d = DONE;
        endcase
      end
      Q_RES: begin
        ctl_o.ld_query = 1'b1;
        state_d = DONE;
      end
      ADD_UPD: begin
        ctl_o.ld_add = 1'b1;
        state_d = (sts_i.vld_rd && !auto_q) ? DONE : PR_RD;
      end
      PR_RD: begin
        ctl_o.rs_sel = frst_pkg::RA_RM1;
        state_d = sts_i.r_zero ? PR_FIN : PR_CNT;
      end
      PR_CNT: begin
        ctl_o.cnt_sel = frst_pkg::CA_RSD;
        ctl_o.ld_oth  = 1'b1;
        state_d = PR_CMP;
      end
      PR_CMP: begin
        if (sts_i.prom_win) begin
          ctl_o.rs_we     = 1'b1;
          ctl_o.rs_ws     = frst_pkg::WS_OTH;
          ctl_o.prom_step = 1'b1;
          state_d = PR_RD;
        end else begin
          state_d = PR_FIN;
        end
      end
      PR_FIN: begin
        ctl_o.rs_we = 1'b1;
        ctl_o.rs_ws = frst_pkg::WS_SYM;
        state_d = DONE;
      end
      SR_CHK: begin
        ctl_o.rs_sel = frst_pkg::RA_I;
        if (sts_i.i_end) begin
          state_d = DONE;
        end else if (sts_i.i_zero) begin
          ctl_o.i_inc = 1'b1;
        end else begin
          state_d = SR_RB;
        end
      end
      SR_RB: begin
        ctl_o.ld_a   = 1'b1;
        ctl_o.rs_sel = frst_pkg::RA_IM1;
        state_d = SR_CA;
      end
      SR_CA: begin
        ctl_o.ld_b    = 1'b1;
        ctl_o.cnt_sel = frst_pkg::CA_A;
        state_d = SR_CB;
      end
      SR_CB: begin
        ctl_o.ld_ca   = 1'b1;
        ctl_o.cnt_sel = frst_pkg::CA_B;
        state_d = SR_CMP;
      end
      SR_CMP: begin
        if (sts_i.sort_win) begin
          ctl_o.rs_we = 1'b1;
          ctl_o.rs_ws = frst_pkg::WS_A;
          state_d = SR_SW;
        end else begin
          ctl_o.i_inc = 1'b1;
          state_d = SR_CHK;
        end
      end
      SR_SW: begin
        ctl_o.rs_we    = 1'b1;
        ctl_o.rs_ws    = frst_pkg::WS_B;
        ctl_o.srt_swap = 1'b1;
        state_d = SR_CHK;
      end
      DONE: begin
        if (!mv_q || out_ready_i) begin
          ctl_o.ld_out = 1'b1;
          mv_d    = 1'b1;
          state_d = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      mv_q    <= 1'b0;
      auto_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mv_q    <= mv_d;
      if (cfg_valid_i) auto_q <= cfg_data_i;
    end
  end

endmodule

[sv/frequency_ranked_symbol_table.sv]
// Frequency ranked symbol table: top level.
// Each accepted word gives one result word. A query, an unused command or a symbol
// beyond the table goes straight to the result; an add bumps the count and promotes the symbol
// if new or with auto_sort set. Sort swaps neighbours out of order, skipped with auto_sort set.
// One word at a time; the output register lets the next word in while a result waits.
// Asynchronous active-low reset empties the table and clears auto_sort; no clearing pass.
module frequency_ranked_symbol_table #(
  parameter int unsigned SYMBOLS     = 256,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,  // command[1:0], symbol[9:2], zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // present[0], was_new[1], rank[9:2], count[41:10], jump[49:42], swaps[64:50],
  // distinct[73:65], total[105:74], zero pad
  output logic [111:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_data_i   // auto_sort
);

  frst_pkg::ctl_t ctl;
  frst_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  frst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  frst_datapath #(
    .SYMBOLS     (SYMBOLS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata)
  );

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[64:50] != 15'd0))
    else $error("sort result marked present");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1]) |-> (m_axis_tdata[0] && m_axis_tdata[41:10] == 32'd1))
    else $error("new symbol without count of one");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[73:65] <= 9'(SYMBOLS)))
    else $error("distinct beyond table size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.ld_out && m_axis_tvalid) |-> m_axis_tready)
    else $error("result overwritten while stalled");
`endif

endmodule

[tb/tb_frequency_ranked_symbol_table.sv]
// Testbench for the frequency ranked symbol table: directed and random words, scoreboard check.
module tb_frequency_ranked_symbol_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 6000000;

  typedef struct packed {
    logic [5:0]  pad;
    logic [31:0] total;
    logic [8:0]  distinct;
    logic [14:0] swaps;
    logic [7:0]  jump;
    logic [31:0] count;
    logic [7:0]  rank;
    logic        was_new;
    logic        present;
  } result_t;

  class rank_scoreboard;
    logic [31:0] sym_count [256];
    logic [7:0]  sym_at_rank [256];
    logic [7:0]  rank_of_sym [256];
    int unsigned n_distinct;
    logic [31:0] sum_count;
    bit          auto_sort;
    result_t     pending [$];
    int unsigned errors;

    function new();
      foreach (sym_count[i]) sym_count[i] = '0;
      n_distinct = 0;
      sum_count  = '0;
      auto_sort  = 1'b0;
      errors     = 0;
    endfunction

    function bit ahead(int unsigned a, int unsigned b);
      return sym_count[a] > sym_count[b] || (sym_count[a] == sym_count[b] && a < b);
    endfunction

    function void swap_up(int unsigned r);
      logic [7:0] hi, lo;
      hi = sym_at_rank[r-1];
      lo = sym_at_rank[r];
      sym_at_rank[r-1] = lo;
      sym_at_rank[r]   = hi;
      rank_of_sym[lo]  = 8'(r - 1);
      rank_of_sym[hi]  = 8'(r);
    endfunction

    function int unsigned promote(int unsigned s);
      int unsigned r, steps;
      r = rank_of_sym[s];
      steps = 0;
      while (r > 0 && ahead(s, sym_at_rank[r-1])) begin
        swap_up(r);
        r--;
        steps++;
      end
      return steps;
    endfunction

    function void note_word(frst_pkg::cmd_e cmd, logic [7:0] s);
      result_t e;
      int unsigned i;
      e = '0;
      if (cmd == frst_pkg::CMD_ADD) begin
        if (sym_count[s] != 0) begin
          if (sym_count[s] != '1) sym_count[s]++;
          if (sum_count != '1) sum_count++;
          if (auto_sort) e.jump = 8'(promote(s));
        end else begin
          sym_count[s] = 1;
          sym_at_rank[n_distinct] = s;
          rank_of_sym[s] = 8'(n_distinct);
          n_distinct++;
          if (sum_count != '1) sum_count++;
          e.was_new = 1'b1;
          e.jump = 8'(promote(s));
        end
      end else if (cmd == frst_pkg::CMD_SORT && !auto_sort) begin
        i = 0;
        while (i < n_distinct) begin
          if (i == 0 || !ahead(sym_at_rank[i], sym_at_rank[i-1])) i++;
          else begin
            swap_up(i);
            e.swaps++;
            i--;
          end
        end
      end
      if ((cmd == frst_pkg::CMD_ADD || cmd == frst_pkg::CMD_QUERY) && sym_count[s] != 0) begin
        e.present = 1'b1;
        e.rank    = rank_of_sym[s];
        e.count   = sym_count[s];
      end
      e.distinct = 9'(n_distinct);
      e.total    = sum_count;
      pending.push_back(e);
    endfunction

    function void check_result(result_t a);
      result_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.present !== e.present) begin
        $error("present exp %0d got %0d", e.present, a.present); errors++;
      end
      if (a.was_new !== e.was_new) begin
        $error("was_new exp %0d got %0d", e.was_new, a.was_new); errors++;
      end
      if (a.rank !== e.rank) begin
        $error("rank exp %0d got %0d", e.rank, a.rank); errors++;
      end
      if (a.count !== e.count) begin
        $error("count exp %0d got %0d", e.count, a.count); errors++;
      end
      if (a.jump !== e.jump) begin
        $error("jump exp %0d got %0d", e.jump, a.jump); errors++;
      end
      if (a.swaps !== e.swaps) begin
        $error("swaps exp %0d got %0d", e.swaps, a.swaps); errors++;
      end
      if (a.distinct !== e.distinct) begin
        $error("distinct exp %0d got %0d", e.distinct, a.distinct); errors++;
      end
      if (a.total !== e.total) begin
        $error("total exp %0d got %0d", e.total, a.total); errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic         cfg_data_i = 1'b0;

  rank_scoreboard sb = new();
  int unsigned    cycles = 0;
  int unsigned    burst_left = 0;
  int unsigned    stall_mode = 0;
  logic [7:0]     hot_base;

  frequency_ranked_symbol_table dut (.*);

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: checks results; stall pattern is redrawn periodically from four modes
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(result_t'(m_axis_tdata));
    if (cycles % 128 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= ((cycles % 16) < 11);
    endcase
  end

  task automatic send_word(frst_pkg::cmd_e cmd, logic [7:0] s);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, s, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_word(cmd, s);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_auto_sort(bit v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.auto_sort = v;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned    k;
    frst_pkg::cmd_e c;
    logic [7:0]     s;
    hot_base = 8'($urandom);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      c = k < 70 ? frst_pkg::CMD_ADD : k < 74 ? frst_pkg::CMD_SORT :
          k < 95 ? frst_pkg::CMD_QUERY : frst_pkg::CMD_NONE;
      s = ($urandom_range(0, 3) != 0) ? 8'(hot_base + $urandom_range(0, 15)) : 8'($urandom);
      send_word(c, s);
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    // empty table, ties, unsorted adds, sort and unused command
    send_word(frst_pkg::CMD_QUERY, 8'd0);
    send_word(frst_pkg::CMD_SORT, 8'd0);
    send_word(frst_pkg::CMD_ADD, 8'd255);
    send_word(frst_pkg::CMD_ADD, 8'd0);
    send_word(frst_pkg::CMD_ADD, 8'd255);
    send_word(frst_pkg::CMD_ADD, 8'd255);
    send_word(frst_pkg::CMD_ADD, 8'hAA);
    send_word(frst_pkg::CMD_ADD, 8'h55);
    send_word(frst_pkg::CMD_QUERY, 8'd255);
    send_word(frst_pkg::CMD_SORT, 8'hFF);
    send_word(frst_pkg::CMD_QUERY, 8'd255);
    send_word(frst_pkg::CMD_QUERY, 8'd7);
    send_word(frst_pkg::CMD_NONE, 8'hFF);
    drain();
    write_auto_sort(1'b1);
    send_word(frst_pkg::CMD_ADD, 8'h55);
    send_word(frst_pkg::CMD_ADD, 8'h55);
    send_word(frst_pkg::CMD_ADD, 8'h55);
    send_word(frst_pkg::CMD_ADD, 8'd1);
    send_word(frst_pkg::CMD_SORT, 8'd0);
    send_word(frst_pkg::CMD_QUERY, 8'h55);
    send_word(frst_pkg::CMD_NONE, 8'd0);
    drain();
    write_auto_sort(1'b0);
    random_phase(480);
    write_auto_sort(1'b1);
    random_phase(480);
    write_auto_sort(1'b0);
    random_phase(480);
    write_auto_sort(1'b1);
    random_phase(480);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

[frequency_ranked_symbol_table.f]
sv/frst_pkg.sv
sv/frst_datapath.sv
sv/frst_ctrl.sv
sv/frequency_ranked_symbol_table.sv
tb/tb_frequency_ranked_symbol_table.sv
